// File: design/rds_pkg.sv
// Shared types and constants for the record descending sorter.
`timescale 1ns / 1ps
package rds_pkg;

  localparam int unsigned WORD_W         = 32;
  localparam int unsigned MAX_RECORD_DEF = 63;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    KIND_ELEM,
    KIND_DROP,
    KIND_TERM
  } item_kind_e;

  typedef struct packed {
    item_kind_e               kind;
    logic signed [WORD_W-1:0] word;
  } q_entry_t;

  typedef enum logic {
    BACK_INSERT,
    BACK_EMIT
  } back_state_e;

endpackage

// File: design/rds_front.sv
// Front end: takes words and tags each as element, dropped element or terminator.
`timescale 1ns / 1ps
module rds_front #(
  parameter int unsigned MaxRecord = rds_pkg::MAX_RECORD_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic signed [rds_pkg::WORD_W-1:0] word_i,
  input  logic                            q_full_i,
  output logic                            busy,
  output logic                            push_o,
  output rds_pkg::q_entry_t               entry_o
);
  import rds_pkg::*;

  localparam int unsigned CntW = $clog2(MaxRecord + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            accept;

  assign busy   = q_full_i;
  assign accept = start && !q_full_i;
  assign push_o = accept;

  always_comb begin
    count_d       = count_q;
    entry_o.word  = word_i;
    entry_o.kind  = KIND_TERM;
    if (word_i == '0) begin
      entry_o.kind = KIND_TERM;
      if (accept) count_d = '0;
    end else if (count_q < CntW'(MaxRecord)) begin
      entry_o.kind = KIND_ELEM;
      if (accept) count_d = count_q + 1'b1;
    end else begin
      entry_o.kind = KIND_DROP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// File: design/rds_queue.sv
// Short queue of tagged words between front and back.
`timescale 1ns / 1ps
module rds_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rds_pkg::q_entry_t entry_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output rds_pkg::q_entry_t entry_o
);
  import rds_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned LvlW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t        mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [LvlW-1:0] level_q;
  logic            do_push, do_pop;

  assign full_o  = (level_q == LvlW'(QUEUE_DEPTH));
  assign empty_o = (level_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      level_q <= level_q + 1'b1;
      else if (do_pop && !do_push) level_q <= level_q - 1'b1;
    end
  end

endmodule

// File: design/rds_back.sv
// Back end: sorted row of cells, parallel insert and shift-out emission.
`timescale 1ns / 1ps
module rds_back #(
  parameter int unsigned MaxRecord = rds_pkg::MAX_RECORD_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  rds_pkg::q_entry_t                 entry_i,
  output logic                              pop_o,
  output logic                              valid_o,
  output logic signed [rds_pkg::WORD_W-1:0] value_o,
  output logic                              last_o,
  output logic                              overflowed_o
);
  import rds_pkg::*;

  localparam int unsigned CntW = $clog2(MaxRecord + 1);

  back_state_e              state_q, state_d;
  logic signed [WORD_W-1:0] cell_q [MaxRecord];
  logic signed [WORD_W-1:0] cell_d [MaxRecord];
  logic [CntW-1:0]          count_q, count_d;
  logic                     lost_q, lost_d;
  logic [MaxRecord-1:0]     goes_below;
  logic                     valid_d, last_d, ovf_d;
  logic signed [WORD_W-1:0] value_d;
  logic                     do_insert;

  // goes_below[i]: new word belongs at or above cell i (monotone along the row)
  always_comb begin
    for (int i = 0; i < MaxRecord; i++) begin
      goes_below[i] = (CntW'(i) < count_q) ? (entry_i.word > cell_q[i]) : 1'b1;
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    lost_d    = lost_q;
    valid_d   = 1'b0;
    value_d   = '0;
    last_d    = 1'b0;
    ovf_d     = 1'b0;
    pop_o     = 1'b0;
    do_insert = 1'b0;
    for (int i = 0; i < MaxRecord; i++) cell_d[i] = cell_q[i];

    unique case (state_q)
      BACK_INSERT: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          unique case (entry_i.kind)
            KIND_ELEM: begin
              do_insert = 1'b1;
              count_d   = count_q + 1'b1;
            end
            KIND_DROP: lost_d  = 1'b1;
            KIND_TERM: state_d = BACK_EMIT;
            default:   lost_d  = lost_q;
          endcase
        end
      end
      BACK_EMIT: begin
        valid_d = 1'b1;
        if (count_q != '0) begin
          value_d = cell_q[0];
          count_d = count_q - 1'b1;
          for (int i = 0; i < MaxRecord - 1; i++) cell_d[i] = cell_q[i+1];
        end else begin
          last_d  = 1'b1;
          ovf_d   = lost_q;
          lost_d  = 1'b0;
          state_d = BACK_INSERT;
        end
      end
      default: state_d = BACK_INSERT;
    endcase

    if (do_insert) begin
      for (int i = 0; i < MaxRecord; i++) begin
        if (goes_below[i]) begin
          if (i == 0) begin
            cell_d[i] = entry_i.word;
          end else begin
            cell_d[i] = goes_below[i-1] ? cell_q[i-1] : entry_i.word;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRecord; i++) cell_q[i] <= cell_d[i];
    value_o      <= value_d;
    last_o       <= last_d;
    overflowed_o <= ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BACK_INSERT;
      count_q <= '0;
      lost_q  <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      lost_q  <= lost_d;
      valid_o <= valid_d;
    end
  end

endmodule

// File: design/record_descending_sorter_top.sv
// Top level of the record descending sorter.
`timescale 1ns / 1ps
// Signed 32-bit words go in on start/word_i; a zero word closes the record.
// An element word is taken into the queue and then settles into a sorted row
// of MaxRecord cells; words past MaxRecord are dropped. On the terminator the
// back end shifts the row out, one word per cycle, largest first, then gives
// the zero with last_o set and overflowed_o reporting any loss. A two-word
// queue sits between front and back; busy is high only while it is full.
// Results appear for a single cycle on valid_o and cannot be held off.
module record_descending_sorter_top #(
  parameter int unsigned MaxRecord = rds_pkg::MAX_RECORD_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rds_pkg::WORD_W-1:0] word_i,
  output logic                              valid_o,
  output logic signed [rds_pkg::WORD_W-1:0] value_o,
  output logic                              last_o,
  output logic                              overflowed_o
);
  import rds_pkg::*;

  q_entry_t push_entry, pop_entry;
  logic     push, pop, q_full, q_empty;

  rds_front #(
    .MaxRecord (MaxRecord)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .word_i   (word_i),
    .q_full_i (q_full),
    .busy     (busy),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  rds_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .entry_o (pop_entry)
  );

  rds_back #(
    .MaxRecord (MaxRecord)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .value_o      (value_o),
    .last_o       (last_o),
    .overflowed_o (overflowed_o)
  );

endmodule

// File: tb/record_descending_sorter_checker.sv
// Checker for the record descending sorter: predicts each record's sorted words and compares them.
`timescale 1ns / 1ps
module record_descending_sorter_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [rds_pkg::WORD_W-1:0] word_i,
  input  logic                              valid_o,
  input  logic signed [rds_pkg::WORD_W-1:0] value_o,
  input  logic                              last_o,
  input  logic                              overflowed_o,
  output int unsigned                       fails_o,
  output int unsigned                       pending_o
);

  import rds_pkg::*;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     last;
    logic                     overflowed;
  } sorted_result_t;

  logic signed [WORD_W-1:0] sorted_words[$];
  logic                     record_lost;
  sorted_result_t           expected_results[$];
  int unsigned              n_fail;

  initial begin
    record_lost = 1'b0;
    n_fail      = 0;
    fails_o     = 0;
    pending_o   = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    n_fail++;
  endtask

  // Insert a nonzero word after equal ones or drop it when full; a zero word closes the record.
  task automatic take_word(input logic signed [WORD_W-1:0] w);
    int pos;
    sorted_result_t r;
    if (w != 0) begin
      if (sorted_words.size() >= MAX_RECORD_DEF) begin
        record_lost = 1'b1;
      end else begin
        pos = 0;
        while (pos < sorted_words.size() && !(w > sorted_words[pos])) pos++;
        sorted_words.insert(pos, w);
      end
    end else begin
      foreach (sorted_words[k]) begin
        r.value      = sorted_words[k];
        r.last       = 1'b0;
        r.overflowed = 1'b0;
        expected_results.push_back(r);
      end
      r.value      = '0;
      r.last       = 1'b1;
      r.overflowed = record_lost;
      expected_results.push_back(r);
      sorted_words.delete();
      record_lost = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    sorted_result_t want;
    if (rst_ni) begin
      // results first: a word taken at this edge cannot have caused one yet
      if (valid_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word value %0d last %0b overflowed %0b",
                                    value_o, last_o, overflowed_o));
        end else begin
          want = expected_results.pop_front();
          if (value_o !== want.value)
            report_mismatch($sformatf("value %0d, expected %0d", value_o, want.value));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", last_o, want.last));
          if (overflowed_o !== want.overflowed)
            report_mismatch($sformatf("overflowed %0b, expected %0b", overflowed_o,
                                      want.overflowed));
        end
      end
      if (start && !busy) take_word(word_i);
    end
    fails_o   <= n_fail;
    pending_o <= expected_results.size();
  end

endmodule

// File: tb/record_descending_sorter_top_test.sv
// Testbench top for the record descending sorter: stimulus, timeout and verdict.
`timescale 1ns / 1ps
module record_descending_sorter_top_test;

  import rds_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_RECORD_DEF + 10;
  localparam int unsigned RANDOM_WORDS = 180;

  logic                     clk_i  = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start  = 1'b0;
  logic                     busy;
  logic signed [WORD_W-1:0] word_i = '0;
  logic                     valid_o;
  logic signed [WORD_W-1:0] value_o;
  logic                     last_o;
  logic                     overflowed_o;
  int unsigned              fails;
  int unsigned              pending;
  int unsigned              cycles = 0;
  int unsigned              idle_pct = 0;
  int unsigned              words_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  record_descending_sorter_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .word_i      (word_i),
    .valid_o     (valid_o),
    .value_o     (value_o),
    .last_o      (last_o),
    .overflowed_o(overflowed_o)
  );

  record_descending_sorter_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .word_i      (word_i),
    .valid_o     (valid_o),
    .value_o     (value_o),
    .last_o      (last_o),
    .overflowed_o(overflowed_o),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one word, possibly after a short gap, and hold it until taken.
  task automatic send_word(input logic signed [WORD_W-1:0] w);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start  <= 1'b1;
    word_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    words_sent++;
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    logic signed [WORD_W-1:0] w;
    case ($urandom_range(9))
      0: w = 32'sh7fff_ffff;
      1: w = 32'sh8000_0000;
      2, 3, 4: begin
        w = $urandom_range(1, 4);
        if ($urandom_range(1)) w = -w;
      end
      default: w = $urandom;
    endcase
    if (w == 0) w = 1;
    return w;
  endfunction

  task automatic send_record(input int unsigned len);
    repeat (len) send_word(pick_word());
    send_word('0);
  endtask

  // Stop offering words, then wait for every expected result.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty records, extremes, duplicates, a lone word
    send_word('0);
    send_word('0);
    send_word(32'sh7fff_ffff);
    send_word(32'sh8000_0000);
    send_word(32'sh0000_0001);
    send_word(32'shffff_ffff);
    send_word(32'sh0000_0005);
    send_word(32'sh0000_0005);
    send_word(-32'sd3);
    send_word(32'sh0000_0005);
    send_word(32'sh8000_0000);
    send_word(32'sh7fff_ffff);
    send_word('0);
    send_word(32'sh8000_0000);
    send_word('0);
    send_word(32'sh5555_5555);
    send_word(32'shaaaa_aaaa);
    send_word('0);

    // exactly full, then one and two past capacity
    send_record(MAX_RECORD_DEF);
    send_record(MAX_RECORD_DEF + 1);
    send_record(MAX_RECORD_DEF + 2);
    wait_drained();

    // sender idling phases: none, heavy, light, none
    for (int p = 0; p < 4; p++) begin
      case (p)
        1:       idle_pct = 66;
        2:       idle_pct = 26;
        default: idle_pct = 0;
      endcase
      phase_end = words_sent + RANDOM_WORDS / 4;
      while (words_sent < phase_end) begin
        r = $urandom_range(99);
        if (r < 8)       send_record(0);
        else if (r < 15) send_record($urandom_range(55, 70));
        else             send_record($urandom_range(1, 10));
      end
      // after the heavy phase, hold off until every result of the phase is out
      if (p == 1) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/rds_pkg.sv
design/rds_front.sv
design/rds_queue.sv
design/rds_back.sv
design/record_descending_sorter_top.sv
tb/record_descending_sorter_checker.sv
tb/record_descending_sorter_top_test.sv
